[rtl/three_axis_fir_lowpass_defines.svh]
// Assertion macros used by the filter's top-level module.
`ifndef THREE_AXIS_FIR_LOWPASS_DEFINES_SVH
`define THREE_AXIS_FIR_LOWPASS_DEFINES_SVH

// Checks an implication on every rising edge outside of reset.
`define TFL_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define TFL_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

[rtl/tfl_pkg.sv]
package tfl_pkg;

    localparam int TAPS_DEF        = 21;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int AXES            = 3;
    localparam int AXIS_W          = 2;
    localparam int COEF_W          = 16;
    localparam int FRAC_BITS       = 16;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_op;

    typedef struct packed {
        logic              rotate;
        logic              push;
        logic              clear;
        logic [AXIS_W-1:0] axis;
    } t_hist_op;

    // Q0.16 taps of the symmetric low-pass; taps past the table are zero.
    function automatic logic [COEF_W-1:0] coef_q16(input int k);
        logic [COEF_W-1:0] c;
        case (k)
            0, 20:   c = 16'd2152;
            1, 19:   c = 16'd2169;
            2, 18:   c = 16'd2507;
            3, 17:   c = 16'd2830;
            4, 16:   c = 16'd3195;
            5, 15:   c = 16'd3332;
            6, 14:   c = 16'd3366;
            7, 13:   c = 16'd3486;
            8, 12:   c = 16'd3820;
            9, 11:   c = 16'd3903;
            10:      c = 16'd4010;
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

[rtl/three_axis_fir_lowpass.sv]
// Each accepted item runs through every tap of the three axes, waits for the three MAC results
// and is then written to the output register; no new item is taken meanwhile, as one
// multiply-accumulate unit serves every tap of all three axes in turn.
// A new item is taken while the previous result still waits in the output register.
// Reset (synchronous, active low) clears the sample histories, the record count,
// the sequencer and the output valid flag.
`include "three_axis_fir_lowpass_defines.svh"

module three_axis_fir_lowpass #(
    parameter int TAPS        = tfl_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = tfl_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                                    i_clk,
    input  logic                                                    i_rst_n,
    input  logic                                                    s_axis_tvalid,
    output logic                                                    s_axis_tready,
    // x_sample, y_sample, z_sample from the lowest bit up, zero padded to bytes.
    input  logic [((tfl_pkg::AXES*SAMPLE_BITS+7)/8)*8-1:0]          s_axis_tdata,
    // last_sample.
    input  logic                                                    s_axis_tlast,
    output logic                                                    m_axis_tvalid,
    input  logic                                                    m_axis_tready,
    // x_filtered, y_filtered, z_filtered from the lowest bit up, zero padded to bytes.
    output logic [((tfl_pkg::AXES*SAMPLE_BITS+7)/8)*8-1:0]          m_axis_tdata,
    // warmed_up.
    output logic [0:0]                                              m_axis_tuser
);
    import tfl_pkg::*;

    localparam int DATA_W = ((AXES * SAMPLE_BITS + 7) / 8) * 8;
    localparam int K_W    = $clog2(TAPS);
    localparam int CNT_W  = $clog2(TAPS + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MAC  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]                              r_state;
    logic [1:0]                              n_state;
    logic [K_W-1:0]                          r_k;
    logic [AXIS_W-1:0]                       r_axis;
    logic [AXIS_W-1:0]                       r_rcnt;
    logic [CNT_W-1:0]                        r_count;
    logic                                    r_last;
    logic [AXES-1:0][SAMPLE_BITS-1:0]        r_fresh;
    logic [AXES-1:0][SAMPLE_BITS-1:0]        r_filt;
    logic                                    r_out_valid;
    logic [DATA_W-1:0]                       r_out_data;
    logic                                    r_out_user;

    logic                                    w_accept;
    logic                                    w_out_free;
    logic                                    w_fin;
    logic                                    w_k_end;
    logic                                    w_axis_end;
    logic signed [SAMPLE_BITS-1:0]           w_fresh_sel;
    logic signed [SAMPLE_BITS-1:0]           w_head;
    logic signed [SAMPLE_BITS-1:0]           w_sample;
    logic [COEF_W-1:0]                       w_coef;
    logic                                    w_res_valid;
    logic signed [SAMPLE_BITS-1:0]           w_res;
    t_mac_op                                 w_mac_op;
    t_hist_op                                w_hist_op;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_fin         = (r_state == S_FIN) && w_out_free;
    assign w_k_end       = (r_k == K_W'(TAPS - 1));
    assign w_axis_end    = (r_axis == AXIS_W'(AXES - 1));

    always_comb begin
        w_fresh_sel = r_fresh[0];
        for (int a = 1; a < AXES; a++) begin
            if (AXIS_W'(a) == r_axis) begin
                w_fresh_sel = r_fresh[a];
            end
        end
    end

    assign w_sample = (r_k == '0) ? w_fresh_sel : w_head;
    assign w_coef   = coef_q16(int'(r_k));

    always_comb begin
        w_mac_op.valid = (r_state == S_MAC);
        w_mac_op.first = (r_k == '0);
        w_mac_op.last  = w_k_end;
        w_hist_op.rotate = (r_state == S_MAC) && (r_k != '0);
        w_hist_op.push   = w_fin && !r_last;
        w_hist_op.clear  = w_fin && r_last;
        w_hist_op.axis   = r_axis;
    end

    tfl_hist #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_hist_op),
        .i_fresh (r_fresh),
        .o_head  (w_head)
    );

    tfl_mac #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_mac_op),
        .i_sample    (w_sample),
        .i_coef      (w_coef),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_MAC;
                end
            end
            S_MAC: begin
                if (w_k_end && w_axis_end) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_res_valid && (r_rcnt == AXIS_W'(AXES - 1))) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_fresh <= s_axis_tdata[AXES*SAMPLE_BITS-1:0];
            r_last  <= s_axis_tlast;
        end
        if (w_res_valid) begin
            for (int a = 0; a < AXES; a++) begin
                if (AXIS_W'(a) == r_rcnt) begin
                    r_filt[a] <= w_res;
                end
            end
        end
        if (w_fin) begin
            r_out_data <= DATA_W'(r_filt);
            r_out_user <= (r_count == CNT_W'(TAPS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_axis      <= '0;
            r_rcnt      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_k    <= '0;
                r_axis <= '0;
                r_rcnt <= '0;
            end else if (r_state == S_MAC) begin
                if (w_k_end) begin
                    r_k    <= '0;
                    r_axis <= r_axis + AXIS_W'(1);
                end else begin
                    r_k <= r_k + K_W'(1);
                end
            end
            if (w_res_valid) begin
                r_rcnt <= r_rcnt + AXIS_W'(1);
            end
            if (w_fin) begin
                if (r_last) begin
                    r_count <= '0;
                end else if (r_count != CNT_W'(TAPS)) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (w_fin) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    `TFL_ASSERT(a_accept_starts, w_accept |=> (r_state == S_MAC && r_k == '0 && r_axis == '0), "accepted item did not start at the first tap")
    `TFL_ASSERT(a_res_in_work, w_res_valid |-> (r_state == S_MAC || r_state == S_WAIT), "MAC result outside of an item")
    `TFL_NEVER(a_count_range, r_count > CNT_W'(TAPS), "record count above the tap count")

endmodule

[rtl/tfl_hist.sv]
module tfl_hist #(
    parameter int TAPS        = 21,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  tfl_pkg::t_hist_op                               i_op,
    input  logic [tfl_pkg::AXES-1:0][SAMPLE_BITS-1:0]       i_fresh,
    output logic signed [SAMPLE_BITS-1:0]                   o_head
);
    import tfl_pkg::*;

    localparam int DEPTH = TAPS - 1;

    logic [AXES-1:0][DEPTH-1:0][SAMPLE_BITS-1:0] r_line;
    logic [AXES-1:0][DEPTH-1:0][SAMPLE_BITS-1:0] n_line;

    // Clear zeroes, push shifts all lines; rotate turns the selected line by one, back in place after DEPTH steps.
    always_comb begin
        n_line = r_line;
        if (i_op.clear) begin
            n_line = '0;
        end else if (i_op.push) begin
            for (int a = 0; a < AXES; a++) begin
                for (int i = DEPTH - 1; i > 0; i--) begin
                    n_line[a][i] = r_line[a][i-1];
                end
                n_line[a][0] = i_fresh[a];
            end
        end else if (i_op.rotate) begin
            for (int a = 0; a < AXES; a++) begin
                if (AXIS_W'(a) == i_op.axis) begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        n_line[a][i] = r_line[a][i+1];
                    end
                    n_line[a][DEPTH-1] = r_line[a][0];
                end
            end
        end
    end

    always_comb begin
        o_head = r_line[0][0];
        for (int a = 1; a < AXES; a++) begin
            if (AXIS_W'(a) == i_op.axis) begin
                o_head = r_line[a][0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line <= '0;
        end else begin
            r_line <= n_line;
        end
    end

endmodule

[rtl/tfl_mac.sv]
module tfl_mac #(
    parameter int TAPS        = 21,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tfl_pkg::t_mac_op                    i_op,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic [tfl_pkg::COEF_W-1:0]          i_coef,
    output logic                                o_res_valid,
    output logic signed [SAMPLE_BITS-1:0]       o_res
);
    import tfl_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] MAXV = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] MINV = -MAXV - ACC_W'(1);

    logic signed [COEF_W:0]      w_coef_s;
    logic signed [PROD_W-1:0]    w_prod;
    logic signed [ACC_W-1:0]     w_rnd;
    logic signed [ACC_W-1:0]     w_q;
    logic signed [SAMPLE_BITS-1:0] w_sat;

    logic signed [PROD_W-1:0]    r_prod;
    logic                        r_pv;
    logic                        r_pfirst;
    logic                        r_plast;
    logic signed [ACC_W-1:0]     r_acc;
    logic signed [ACC_W-1:0]     n_acc;
    logic                        r_adone;
    logic signed [SAMPLE_BITS-1:0] r_res;
    logic                        r_rdone;

    assign w_coef_s = {1'b0, i_coef};
    assign w_prod   = i_sample * w_coef_s;
    assign n_acc    = (r_pfirst ? '0 : r_acc) + ACC_W'(r_prod);
    assign w_rnd    = r_acc + HALF;
    assign w_q      = w_rnd >>> FRAC_BITS;

    always_comb begin
        if (w_q > MAXV) begin
            w_sat = MAXV[SAMPLE_BITS-1:0];
        end else if (w_q < MINV) begin
            w_sat = MINV[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_q[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.valid) begin
            r_prod <= w_prod;
        end
        if (r_pv) begin
            r_acc <= n_acc;
        end
        if (r_adone) begin
            r_res <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv     <= 1'b0;
            r_pfirst <= 1'b0;
            r_plast  <= 1'b0;
            r_adone  <= 1'b0;
            r_rdone  <= 1'b0;
        end else begin
            r_pv     <= i_op.valid;
            r_pfirst <= i_op.valid & i_op.first;
            r_plast  <= i_op.valid & i_op.last;
            r_adone  <= r_pv & r_plast;
            r_rdone  <= r_adone;
        end
    end

    assign o_res_valid = r_rdone;
    assign o_res       = r_res;

endmodule

[test/tb_three_axis_fir_lowpass.sv]
module tb_three_axis_fir_lowpass;

    localparam int SW         = tfl_pkg::SAMPLE_BITS_DEF;
    localparam int DW         = ((tfl_pkg::AXES * SW + 7) / 8) * 8;
    localparam int NTAPS      = tfl_pkg::TAPS_DEF;
    localparam int HIST       = NTAPS - 1;
    localparam int STALL_LEN  = 500;
    localparam int TAIL_WAIT  = 3 * NTAPS + 20;
    localparam int QUIET_MAX  = 4000;

    typedef struct packed {
        logic          last;
        logic [SW-1:0] z;
        logic [SW-1:0] y;
        logic [SW-1:0] x;
    } t_sample;

    typedef struct packed {
        logic          warm;
        logic [SW-1:0] z;
        logic [SW-1:0] y;
        logic [SW-1:0] x;
    } t_filt;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [DW-1:0] s_axis_tdata = '0;   // x_sample, y_sample, z_sample
    logic          s_axis_tlast = 1'b0; // last_sample
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [DW-1:0] m_axis_tdata;        // x_filtered, y_filtered, z_filtered
    logic [0:0]    m_axis_tuser;        // warmed_up

    three_axis_fir_lowpass dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    int tap_q16 [NTAPS] = '{2152, 2169, 2507, 2830, 3195, 3332, 3366, 3486, 3820, 3903, 4010,
                            3903, 3820, 3486, 3366, 3332, 3195, 2830, 2507, 2169, 2152};

    shortint axis_hist [3][HIST];
    int      rec_len;

    t_sample feed_q [$];
    t_filt   filt_q [$];

    int in_cnt = 0;
    int out_cnt = 0;
    int warm_cnt = 0;
    int rec_cnt = 0;
    int err_cnt = 0;
    int src_gap = 0;
    int stall_left = 0;
    int quiet = 0;
    bit stall_done = 1'b0;
    bit steady;

    assign steady = (in_cnt >= 900) && (in_cnt < 1150);

    function automatic t_filt filter_sample(t_sample s);
        t_filt   r;
        shortint fresh [3];
        logic [SW-1:0] res [3];
        longint  acc;
        longint  q;
        int      a;
        int      k;
        fresh[0] = shortint'(s.x);
        fresh[1] = shortint'(s.y);
        fresh[2] = shortint'(s.z);
        r.warm = (rec_len >= NTAPS);
        for (a = 0; a < 3; a++) begin
            acc = longint'(fresh[a]) * tap_q16[0];
            for (k = 1; k < NTAPS; k++) begin
                acc += longint'(axis_hist[a][k-1]) * tap_q16[k];
            end
            q = (acc + 32768) >>> 16;
            if (q > 32767) q = 32767;
            if (q < -32768) q = -32768;
            res[a] = q[SW-1:0];
            for (k = HIST - 1; k > 0; k--) begin
                axis_hist[a][k] = axis_hist[a][k-1];
            end
            axis_hist[a][0] = fresh[a];
        end
        r.x = res[0];
        r.y = res[1];
        r.z = res[2];
        if (rec_len < NTAPS) rec_len++;
        if (s.last) begin
            rec_len = 0;
            for (a = 0; a < 3; a++) begin
                for (k = 0; k < HIST; k++) axis_hist[a][k] = 0;
            end
        end
        return r;
    endfunction

    function automatic logic [SW-1:0] pick_axis(int style, logic [SW-1:0] base);
        logic [SW-1:0] v;
        case (style)
            0: v = SW'($urandom_range(0, 65535));
            1: begin
                case ($urandom_range(0, 4))
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    2: v = 16'h0000;
                    3: v = 16'hFFFF;
                    default: v = 16'h0001;
                endcase
            end
            2: v = base + SW'($urandom_range(0, 511)) - SW'(256);
            default: v = base;
        endcase
        return v;
    endfunction

    task automatic queue_records(int n);
        int      added;
        int      len;
        int      style;
        int      i;
        int      sel;
        logic [SW-1:0] bx, by, bz;
        t_sample s;
        added = 0;
        while (added < n) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) len = $urandom_range(NTAPS + 1, 60);
            else if (sel < 9) len = $urandom_range(1, NTAPS);
            else len = $urandom_range(1, 3);
            style = $urandom_range(0, 3);
            bx = SW'($urandom_range(0, 65535));
            by = SW'($urandom_range(0, 65535));
            bz = SW'($urandom_range(0, 65535));
            for (i = 0; i < len; i++) begin
                s.x = pick_axis(style, bx);
                s.y = pick_axis(style, by);
                s.z = pick_axis(style, bz);
                s.last = (i == len - 1);
                feed_q.push_back(s);
            end
            added += len;
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        while (feed_q.size() != 0 || s_axis_tvalid || filt_q.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : driver
        t_sample nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            src_gap       <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (src_gap != 0) begin
                s_axis_tvalid <= 1'b0;
                src_gap       <= src_gap - 1;
            end else if (feed_q.size() != 0) begin
                nxt = feed_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt.z, nxt.y, nxt.x};
                s_axis_tlast  <= nxt.last;
                if (!steady && $urandom_range(0, 99) < 9) src_gap <= $urandom_range(1, 140);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!stall_done && out_cnt >= 300) begin
            m_axis_tready <= 1'b0;
            stall_left    <= STALL_LEN;
            stall_done    <= 1'b1;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= 9);
        end
    end

    always @(posedge i_clk) begin : monitor
        t_filt got;
        t_filt want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                filt_q.push_back(filter_sample({s_axis_tlast, s_axis_tdata[3*SW-1:0]}));
                in_cnt  <= in_cnt + 1;
                rec_cnt <= rec_cnt + s_axis_tlast;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser[0], m_axis_tdata[3*SW-1:0]};
                out_cnt  <= out_cnt + 1;
                warm_cnt <= warm_cnt + got.warm;
                if (filt_q.size() == 0) begin
                    $display("%0t unexpected result: expected none, got x %0d y %0d z %0d warm %0b",
                             $time, $signed(got.x), $signed(got.y), $signed(got.z), got.warm);
                    err_cnt++;
                end else begin
                    want = filt_q.pop_front();
                    if (got !== want) begin
                        err_cnt++;
                        if (got.x !== want.x)
                            $display("%0t x_filtered: expected %0d, got %0d",
                                     $time, $signed(want.x), $signed(got.x));
                        if (got.y !== want.y)
                            $display("%0t y_filtered: expected %0d, got %0d",
                                     $time, $signed(want.y), $signed(got.y));
                        if (got.z !== want.z)
                            $display("%0t z_filtered: expected %0d, got %0d",
                                     $time, $signed(want.z), $signed(got.z));
                        if (got.warm !== want.warm)
                            $display("%0t warmed_up: expected %0b, got %0b",
                                     $time, want.warm, got.warm);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin : stimulus
        t_sample s;
        int      i;
        // A full-scale record long enough to warm up, with alternating bit patterns on z.
        for (i = 0; i < NTAPS + 2; i++) begin
            s.x = 16'h7FFF;
            s.y = 16'h8000;
            s.z = i[0] ? 16'h5555 : 16'hAAAA;
            s.last = (i == NTAPS + 1);
            feed_q.push_back(s);
        end
        // A record of a single sample.
        s.x = 16'h8000;
        s.y = 16'h7FFF;
        s.z = 16'h0000;
        s.last = 1'b1;
        feed_q.push_back(s);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait_drained();
        queue_records(700);
        wait_drained();
        queue_records(780);
        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("Filtered %0d three-axis samples in %0d records; %0d results came after warm-up.",
                 in_cnt, rec_cnt, warm_cnt);
        $display("Both sides stalled at random, with one long output hold and drained pauses.");
        if (err_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
